@@ src/tcc_pkg.sv @@
`default_nettype none
package tcc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CELL_W-1:0] t_cell;

    localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);
    localparam t_addr            CELL_LAST   = ADDR_W'(CELLS - 1);
    localparam t_addr            COPY_LAST   = ADDR_W'(CELLS - COLUMNS - 1);
    localparam t_addr            SCROLL_BASE = ADDR_W'(CELLS - COLUMNS);
    localparam t_addr            COPY_SRC    = ADDR_W'(COLUMNS);
    localparam t_addr            COPY_AHEAD  = ADDR_W'(COLUMNS + 1);

    localparam logic [CHAR_W-1:0]  CODE_BS     = 8'd8;
    localparam logic [CHAR_W-1:0]  CODE_NL     = 8'd10;
    localparam logic [CHAR_W-1:0]  CODE_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0]  CODE_LAST   = 8'd126;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;
    localparam t_cell              RESET_CELL  = {COLOR_RESET, CODE_SPACE};

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_SET   = 3'd2,
        OP_EOL   = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL_START,
        ST_COPY,
        ST_BLANK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [POS_W-1:0]  pos;
        t_cell             data;
    } t_resp;

    function automatic t_addr cell_addr(input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * COLUMNS + int'(c));
    endfunction

endpackage
`default_nettype wire

@@ src/tcc_if.sv @@
`default_nettype none
interface tcc_in_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;

    modport source (output valid, op, char_code, row, col, input ready);
    modport sink   (input valid, op, char_code, row, col, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, cur_row, cur_col, cursor_position, cell_value,
                    input ready);
    modport sink   (input valid, cur_row, cur_col, cursor_position, cell_value,
                    output ready);
endinterface
`default_nettype wire

@@ src/tcc_cell_ram.sv @@
`default_nettype none
module tcc_cell_ram
    import tcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_cell         o_rdata
);

    t_cell r_mem [CELLS];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/tcc_ctrl.sv @@
`default_nettype none
module tcc_ctrl
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire logic [COL_W-1:0]   i_col,
    input  wire logic [COLOR_W-1:0] i_color,
    input  wire logic               i_out_free,
    input  wire t_cell              i_rdata,
    output logic                    o_idle,
    output t_ram_req                o_ram,
    output t_resp                   o_resp
);

    t_state           r_state, n_state;
    t_addr            r_addr, n_addr;
    t_addr            r_end, n_end;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_rd_ok, n_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_addr  <= '0;
            r_end   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_end   <= n_end;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_comb begin
        logic wrap;
        n_state = r_state;
        n_addr  = r_addr;
        n_end   = r_end;
        n_row   = r_row;
        n_col   = r_col;
        n_rd_ok = r_rd_ok;
        wrap    = 1'b0;
        o_ram   = '0;
        o_resp  = '0;
        o_idle  = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = RESET_CELL;
                if (r_addr == CELL_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = ST_RESP;
                    n_rd_ok = 1'b0;
                    unique case (t_op'(i_op))
                        OP_PUT: begin
                            if (i_char_code == CODE_BS) begin
                                if (r_col != '0) begin
                                    n_col       = r_col - 1'b1;
                                    o_ram.we    = 1'b1;
                                    o_ram.waddr = cell_addr(r_row, r_col - 1'b1);
                                    o_ram.wdata = {i_color, CODE_SPACE};
                                end
                            end else if (i_char_code == CODE_NL) begin
                                n_col = '0;
                                wrap  = 1'b1;
                            end else if (i_char_code >= CODE_SPACE &&
                                         i_char_code <= CODE_LAST) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = cell_addr(r_row, r_col);
                                o_ram.wdata = {i_color, i_char_code};
                                if (r_col == COL_LAST) begin
                                    n_col = '0;
                                    wrap  = 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            // moving past the bottom row scrolls, cursor stays there
                            if (wrap) begin
                                if (r_row == ROW_LAST) begin
                                    n_state = ST_SCROLL_START;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_addr  = '0;
                            n_end   = CELL_LAST;
                            n_state = ST_BLANK;
                        end
                        OP_SET: begin
                            n_row = (i_row > ROW_LAST) ? ROW_LAST : i_row;
                            n_col = (i_col > COL_LAST) ? COL_LAST : i_col;
                        end
                        OP_EOL: begin
                            n_addr  = cell_addr(r_row, r_col);
                            n_end   = cell_addr(r_row, COL_LAST);
                            n_state = ST_BLANK;
                        end
                        OP_READ: begin
                            if (i_row <= ROW_LAST && i_col <= COL_LAST) begin
                                n_rd_ok     = 1'b1;
                                o_ram.re    = 1'b1;
                                o_ram.raddr = cell_addr(i_row, i_col);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL_START: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = COPY_SRC;
                n_addr      = '0;
                n_state     = ST_COPY;
            end
            ST_COPY: begin
                // read runs one row plus one cell ahead of the write
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = i_rdata;
                if (r_addr == COPY_LAST) begin
                    n_addr  = SCROLL_BASE;
                    n_end   = CELL_LAST;
                    n_state = ST_BLANK;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_addr + COPY_AHEAD;
                    n_addr      = r_addr + 1'b1;
                end
            end
            ST_BLANK: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = {i_color, CODE_SPACE};
                if (r_addr == r_end) begin
                    n_state = ST_RESP;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_RESP: begin
                if (i_out_free) begin
                    o_resp.valid = 1'b1;
                    o_resp.row   = r_row;
                    o_resp.col   = r_col;
                    o_resp.pos   = POS_W'(cell_addr(r_row, r_col));
                    o_resp.data  = r_rd_ok ? i_rdata : '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_LAST) && (r_col <= COL_LAST))
        else $error("cursor out of range");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (o_ram.waddr <= CELL_LAST))
        else $error("cell store write out of range");

    a_copy_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> $past(o_ram.re))
        else $error("scroll copy without a read issued");

    a_resp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && !i_out_free) |=> (r_state == ST_RESP))
        else $error("result dropped while output busy");
`endif

endmodule
`default_nettype wire

@@ src/text_console_cursor_engine.sv @@
`default_nettype none
// Text console engine with an 80x25 store of 16-bit cells (color high byte, character low
// byte). After reset the block runs a clearing pass over all 2000 cells, one per cycle,
// before it takes its first request; color writes are taken meanwhile. Put char, set
// cursor, read cell and unused ops go from accept straight to respond. Everything else is
// bound by the single write port of the cell store: clear to end of line writes the
// 80 - column cells from the cursor on, clear screen all 2000 cells, and a put char that
// scrolls adds one row-ahead read, 1920 copies and 80 blanks. Results go through an
// output register, so a new request is accepted while the last result waits.
module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tcc_in_if.sink                  i_in,
    tcc_out_if.source               o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [COLOR_W-1:0] i_cfg_data
);

    logic [COLOR_W-1:0] r_color;
    logic               r_out_valid;
    t_resp              r_out;
    logic               w_idle;
    logic               w_out_free;
    t_ram_req           w_ram;
    t_cell              w_rdata;
    t_resp              w_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && w_idle),
        .i_op        (i_in.op),
        .i_char_code (i_in.char_code),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_color     (r_color),
        .i_out_free  (w_out_free),
        .i_rdata     (w_rdata),
        .o_idle      (w_idle),
        .o_ram       (w_ram),
        .o_resp      (w_resp)
    );

    tcc_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_resp.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_resp.valid) begin
            r_out <= w_resp;
        end
    end

    assign i_in.ready            = w_idle;
    assign o_out.valid           = r_out_valid;
    assign o_out.cur_row         = r_out.row;
    assign o_out.cur_col         = r_out.col;
    assign o_out.cursor_position = r_out.pos;
    assign o_out.cell_value      = r_out.data;

endmodule
`default_nettype wire
